// ----- rtl/pbd_pkg.sv -----
`default_nettype none

package pbd_pkg;

  typedef enum logic [2:0] {
    KIND_NUM  = 3'd0,
    KIND_LEN  = 3'd1,
    KIND_DATA = 3'd2,
    KIND_DONE = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_KEY   = 3'd1,
    ERR_NUM   = 3'd2,
    ERR_BYTES = 3'd3,
    ERR_FIELD = 3'd4
  } err_t;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_KEY     = 7'b0000010,
    PH_NUM     = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_DATA    = 7'b0010000,
    PH_SKIPVAR = 7'b0100000,
    PH_SKIPFIX = 7'b1000000
  } phase_t;

  localparam logic       CMD_START   = 1'b0;
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;
  localparam logic [31:0] FIELD_BOOL = 32'd6;
  localparam logic [31:0] FIELD_U32  = 32'd9;
  localparam logic [3:0]  VARINT_LAST = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] field_number;
    logic [63:0] value;
    logic [7:0]  byte_out;
    logic        end_of_field;
    err_t        error_code;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic res_t mk_res(input kind_t k, input logic [31:0] f,
                                  input logic [63:0] v, input logic [7:0] b,
                                  input logic e, input err_t c);
    res_t r;
    r.kind         = k;
    r.field_number = f;
    r.value        = v;
    r.byte_out     = b;
    r.end_of_field = e;
    r.error_code   = c;
    return r;
  endfunction

  function automatic logic [5:0] vshift(input logic [3:0] cnt);
    logic [5:0] s;
    unique case (cnt)
      4'd0: s = 6'd0;
      4'd1: s = 6'd7;
      4'd2: s = 6'd14;
      4'd3: s = 6'd21;
      4'd4: s = 6'd28;
      4'd5: s = 6'd35;
      4'd6: s = 6'd42;
      4'd7: s = 6'd49;
      4'd8: s = 6'd56;
      default: s = 6'd63;
    endcase
    return s;
  endfunction

  function automatic logic is_numeric(input logic [31:0] f);
    return f == 32'd1 || f == 32'd2 || f == 32'd4 || f == 32'd5 ||
           f == FIELD_BOOL || f == FIELD_U32;
  endfunction

  function automatic logic is_bytes(input logic [31:0] f);
    return f == 32'd3 || f == 32'd7 || f == 32'd8 || f == 32'd10;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pbd_chan_if.sv -----
`default_nettype none

interface pbd_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, payload_length, data_byte, input ready);
  modport sink   (input valid, cmd, payload_length, data_byte, output ready);
endinterface

interface pbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] field_number;
  logic [63:0] value;
  logic [7:0]  byte_out;
  logic        end_of_field;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, kind, field_number, value, byte_out, end_of_field,
                  error_code, last, input ready);
  modport sink   (input valid, kind, field_number, value, byte_out, end_of_field,
                  error_code, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pbd_front.sv -----
`default_nettype none

module pbd_front import pbd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  pbd_in_if.sink in_ch,
  input  logic   q_full,
  output push_t  push
);

  phase_t      phase_r, ph_nxt;
  logic [63:0] accum_r, acc_nxt;
  logic [3:0]  count_r, cnt_nxt;
  logic [31:0] field_r, fld_nxt;
  logic [31:0] pleft_r, pl_nxt;
  logic [31:0] fbleft_r, fbl_nxt;

  logic        take;
  logic [63:0] vi_val;
  logic        vi_done, vi_long;
  logic [31:0] pl_dec, fbl_dec, key_fld, need;
  logic [2:0]  key_wire;
  logic        known;
  logic [63:0] num_val;
  logic        has_a, has_b, fail_a;
  err_t        code_a;
  res_t        res_a, res_b;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  assign vi_val   = accum_r | (64'(in_ch.data_byte[6:0]) << vshift(count_r));
  assign vi_done  = !in_ch.data_byte[7];
  assign vi_long  = in_ch.data_byte[7] && (count_r >= VARINT_LAST);
  assign pl_dec   = pleft_r - 32'd1;
  assign fbl_dec  = (fbleft_r != 32'd0) ? fbleft_r - 32'd1 : 32'd0;
  assign key_fld  = vi_val[34:3];
  assign key_wire = vi_val[2:0];
  assign known    = is_bytes(field_r);
  assign need     = (key_wire == WIRE_I64) ? 32'd8 : 32'd4;

  always_comb begin
    if (field_r == FIELD_BOOL) begin
      num_val = {63'd0, |vi_val};
    end else if (field_r == FIELD_U32) begin
      num_val = {32'd0, vi_val[31:0]};
    end else begin
      num_val = vi_val;
    end
  end

  always_comb begin
    ph_nxt  = phase_r;
    acc_nxt = accum_r;
    cnt_nxt = count_r;
    fld_nxt = field_r;
    pl_nxt  = pleft_r;
    fbl_nxt = fbleft_r;
    has_a   = 1'b0;
    has_b   = 1'b0;
    fail_a  = 1'b0;
    code_a  = ERR_NONE;
    res_a   = '0;
    res_b   = '0;
    if (take) begin
      if (in_ch.cmd == CMD_START) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        fld_nxt = '0;
        fbl_nxt = '0;
        pl_nxt  = in_ch.payload_length;
        if (in_ch.payload_length == 32'd0) begin
          ph_nxt = PH_IDLE;
          has_a  = 1'b1;
          res_a  = mk_res(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE);
        end else begin
          ph_nxt = PH_KEY;
        end
      end else if (phase_r != PH_IDLE && pleft_r != 32'd0) begin
        pl_nxt = pl_dec;
        if (phase_r == PH_KEY || phase_r == PH_NUM || phase_r == PH_LEN ||
            phase_r == PH_SKIPVAR) begin
          if (vi_done || vi_long) begin
            acc_nxt = '0;
            cnt_nxt = '0;
          end else begin
            acc_nxt = vi_val;
            cnt_nxt = count_r + 4'd1;
          end
        end
        unique case (phase_r)
          PH_KEY: begin
            if (vi_long) begin
              fail_a = 1'b1;
              code_a = ERR_KEY;
            end else if (vi_done) begin
              fld_nxt = key_fld;
              if (is_numeric(key_fld)) begin
                if (key_wire != WIRE_VARINT) begin
                  fail_a = 1'b1;
                  code_a = ERR_NUM;
                end else begin
                  ph_nxt = PH_NUM;
                end
              end else if (is_bytes(key_fld)) begin
                if (key_wire != WIRE_LEN) begin
                  fail_a = 1'b1;
                  code_a = ERR_BYTES;
                end else begin
                  ph_nxt = PH_LEN;
                end
              end else if (key_wire == WIRE_VARINT) begin
                ph_nxt = PH_SKIPVAR;
              end else if (key_wire == WIRE_LEN) begin
                ph_nxt = PH_LEN;
              end else if (key_wire == WIRE_I64 || key_wire == WIRE_I32) begin
                if (pl_dec < need) begin
                  fail_a = 1'b1;
                  code_a = ERR_FIELD;
                end else begin
                  fbl_nxt = need;
                  ph_nxt  = PH_SKIPFIX;
                end
              end else begin
                fail_a = 1'b1;
                code_a = ERR_FIELD;
              end
            end
          end
          PH_NUM: begin
            if (vi_long) begin
              fail_a = 1'b1;
              code_a = ERR_NUM;
            end else if (vi_done) begin
              has_a  = 1'b1;
              res_a  = mk_res(KIND_NUM, field_r, num_val, '0, 1'b0, ERR_NONE);
              ph_nxt = PH_KEY;
            end
          end
          PH_LEN: begin
            if (vi_long || (vi_done && vi_val > {32'd0, pl_dec})) begin
              fail_a = 1'b1;
              code_a = known ? ERR_BYTES : ERR_FIELD;
            end else if (vi_done) begin
              if (known) begin
                has_a = 1'b1;
                res_a = mk_res(KIND_LEN, field_r, vi_val, '0, 1'b0, ERR_NONE);
              end
              if (vi_val == 64'd0) begin
                ph_nxt = PH_KEY;
              end else begin
                fbl_nxt = vi_val[31:0];
                ph_nxt  = known ? PH_DATA : PH_SKIPFIX;
              end
            end
          end
          PH_DATA: begin
            fbl_nxt = fbl_dec;
            has_a   = 1'b1;
            res_a   = mk_res(KIND_DATA, field_r, '0, in_ch.data_byte,
                             fbl_dec == 32'd0, ERR_NONE);
            if (fbl_dec == 32'd0) begin
              ph_nxt = PH_KEY;
            end
          end
          PH_SKIPVAR: begin
            if (vi_long) begin
              fail_a = 1'b1;
              code_a = ERR_FIELD;
            end else if (vi_done) begin
              ph_nxt = PH_KEY;
            end
          end
          PH_SKIPFIX: begin
            fbl_nxt = fbl_dec;
            if (fbl_dec == 32'd0) begin
              ph_nxt = PH_KEY;
            end
          end
          default: begin
          end
        endcase
        if (fail_a) begin
          ph_nxt  = PH_IDLE;
          acc_nxt = '0;
          cnt_nxt = '0;
          has_a   = 1'b1;
          res_a   = mk_res(KIND_ERR, (code_a == ERR_KEY) ? 32'd0 : fld_nxt, '0, '0,
                           1'b0, code_a);
        end else if (ph_nxt != PH_IDLE && pl_dec == 32'd0) begin
          has_b = 1'b1;
          if (ph_nxt == PH_KEY && cnt_nxt == 4'd0) begin
            res_b = mk_res(KIND_DONE, '0, '0, '0, 1'b0, ERR_NONE);
          end else if (ph_nxt == PH_KEY) begin
            res_b = mk_res(KIND_ERR, '0, '0, '0, 1'b0, ERR_KEY);
          end else if (ph_nxt == PH_NUM) begin
            res_b = mk_res(KIND_ERR, fld_nxt, '0, '0, 1'b0, ERR_NUM);
          end else if ((ph_nxt == PH_LEN || ph_nxt == PH_DATA) && is_bytes(fld_nxt)) begin
            res_b = mk_res(KIND_ERR, fld_nxt, '0, '0, 1'b0, ERR_BYTES);
          end else begin
            res_b = mk_res(KIND_ERR, fld_nxt, '0, '0, 1'b0, ERR_FIELD);
          end
          ph_nxt  = PH_IDLE;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
    end
  end

  assign push.valid    = take && (has_a || has_b);
  assign push.entry.r0 = has_a ? res_a : res_b;
  assign push.entry.r1 = res_b;
  assign push.entry.two = has_a && has_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      accum_r  <= '0;
      count_r  <= '0;
      field_r  <= '0;
      pleft_r  <= '0;
      fbleft_r <= '0;
    end else begin
      phase_r  <= ph_nxt;
      accum_r  <= acc_nxt;
      count_r  <= cnt_nxt;
      field_r  <= fld_nxt;
      pleft_r  <= pl_nxt;
      fbleft_r <= fbl_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= VARINT_LAST)
    else $error("Varint byte count ran past the tenth byte.");

  assert property (@(posedge clk) disable iff (!rst_n)
                   phase_r != PH_IDLE |-> pleft_r != 32'd0)
    else $error("Decoder is active with no payload bytes left.");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (phase_r == PH_DATA || phase_r == PH_SKIPFIX) |-> fbleft_r != 32'd0)
    else $error("Field body phase entered with an empty byte count.");

endmodule

`default_nettype wire

// ----- rtl/pbd_queue.sv -----
`default_nettype none

module pbd_queue import pbd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));

  function automatic logic [QPTR_W-1:0] nxt_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= nxt_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= nxt_ptr(rd_ptr_r);
      end
      if (push.valid && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push.valid) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= QCNT_W'(QDEPTH))
    else $error("Queue fill count exceeds its depth.");

  assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !full)
    else $error("Write into a full queue.");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("Read from an empty queue.");

endmodule

`default_nettype wire

// ----- rtl/pbd_back.sv -----
`default_nettype none

module pbd_back import pbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  pbd_out_if.source   out_ch
);

  logic sub_r;
  logic is_last;
  logic xfer;
  res_t res;

  assign res     = sub_r ? head.r1 : head.r0;
  assign is_last = sub_r || !head.two;
  assign xfer    = out_ch.valid && out_ch.ready;
  assign pop     = xfer && is_last;

  assign out_ch.valid        = !empty;
  assign out_ch.kind         = res.kind;
  assign out_ch.field_number = res.field_number;
  assign out_ch.value        = res.value;
  assign out_ch.byte_out     = res.byte_out;
  assign out_ch.end_of_field = res.end_of_field;
  assign out_ch.error_code   = res.error_code;
  assign out_ch.last         = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else if (xfer) begin
      sub_r <= !is_last;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) sub_r |-> (!empty && head.two))
    else $error("Second result selected without a two-result entry.");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (xfer && !is_last) |=> (sub_r && !empty))
    else $error("First of two results left without its partner.");

endmodule

`default_nettype wire

// ----- rtl/protobuf_stream_field_decoder_core.sv -----
`default_nettype none

// Channel   Direction  Handshake     Payload
// in_ch     sink       valid/ready   cmd, payload_length, data_byte
// out_ch    source     valid/ready   kind, field_number, value, byte_out,
//                                    end_of_field, error_code, last
//
// The decoder takes one input transfer per cycle while the queue is not full; each
// item is decoded in the cycle it is accepted and its zero, one or two results
// enter a four-entry queue. Results leave one per cycle while out_ch is ready, so
// a two-result item holds the output for both; the queue absorbs the difference.
// Input ready drops only while the queue is full; output stalls fill the queue.
// Reset is synchronous and returns the decoder to waiting for a start item.

module protobuf_stream_field_decoder_core import pbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pbd_in_if.sink     in_ch,
  pbd_out_if.source  out_ch
);

  push_t  push;
  entry_t head;
  logic   q_empty, q_full, q_pop;

  pbd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  pbd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  pbd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
